FILE: sv/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Types, widths and codes shared by the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int VERTEX_COUNT_DEF    = 1024;
   localparam int NORMAL_SUM_BITS_DEF = 24;

   localparam int INDEX_W  = 10;
   localparam int POS_W    = 16;
   localparam int NORMAL_W = 24;
   localparam int EDGE_W   = 17;
   localparam int PROD_W   = 34;
   localparam int CROSS_W  = 35;
   localparam int MAG_W    = 34;
   localparam int SCALED_W = 30;
   localparam int SQ_W     = 64;
   localparam int LEN_W    = 32;
   localparam int REM_W    = 31;
   localparam int NUM_W    = 46;
   localparam int QUOT_W   = 17;
   localparam int UNIT_W   = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_TRIANGLE = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   typedef struct packed {
      logic [1:0]               command;
      logic [INDEX_W-1:0]       index_a;
      logic [INDEX_W-1:0]       index_b;
      logic [INDEX_W-1:0]       index_c;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]         vertex_index;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_TRIANGLE,
      OP_READ,
      OP_READ_ZERO
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [INDEX_W-1:0]       index_a;
      logic [INDEX_W-1:0]       index_b;
      logic [INDEX_W-1:0]       index_c;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } job_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SCALE,
      N_SQUARE,
      N_ROOT,
      N_DIV_LOAD,
      N_DIV_STEP,
      N_DONE
   } norm_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_LOAD,
      B_FETCH,
      B_CATCH,
      B_EDGE,
      B_CROSS,
      B_NORM_GO,
      B_NORM_WAIT,
      B_ACC_RD,
      B_ACC_WR,
      B_RD_ISSUE,
      B_RSP
   } back_state_type;

endpackage

FILE: sv/vertex_normal_accumulator.sv
// Throughput: one request at a time in the back end; a triangle is bound by the
//   32-step square root and three serial divisions in the normaliser.
// Reset: synchronous, active high; clears the queue, the sequencers and the
//   response valid flag. Memory contents are not cleared; a vertex must be loaded.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Per-vertex sum of unit face normals over a store of Q8.8 positions.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
   parameter int VERTEX_COUNT    = vna_pkg::VERTEX_COUNT_DEF,
   parameter int NORMAL_SUM_BITS = vna_pkg::NORMAL_SUM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vna_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vna_pkg::rsp_type  rsp_data
);
   import vna_pkg::*;

   // front -> queue -> back; the queue lets requests land while a triangle runs
   logic    push, pop, queue_full, queue_not_empty;
   job_type push_job, pop_job;

   // front: index range check, spare command and bad corners dropped here
   vna_front #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   vna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .pop_job   (pop_job),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   // back: memories, cross product, normaliser and saturating update
   vna_back #(
      .VERTEX_COUNT    (VERTEX_COUNT),
      .NORMAL_SUM_BITS (NORMAL_SUM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Takes requests, checks indices and turns each kept one into a job for the queue.
// ----------------------------------------------------------------------------
module vna_front #(
   parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  vna_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              push,
   output vna_pkg::job_type  job
);
   import vna_pkg::*;

   logic   a_ok, b_ok, c_ok, keep;
   op_type op;

   assign a_ok = 32'(req_data.index_a) < VERTEX_COUNT;
   assign b_ok = 32'(req_data.index_b) < VERTEX_COUNT;
   assign c_ok = 32'(req_data.index_c) < VERTEX_COUNT;

   // out-of-range loads and triangles and the spare command are dropped
   always_comb begin
      unique case (req_data.command)
         CMD_LOAD: begin
            keep = a_ok;
            op   = OP_LOAD;
         end
         CMD_TRIANGLE: begin
            keep = a_ok && b_ok && c_ok;
            op   = OP_TRIANGLE;
         end
         CMD_READ: begin
            keep = 1'b1;
            op   = a_ok ? OP_READ : OP_READ_ZERO;
         end
         default: begin
            keep = 1'b0;
            op   = OP_LOAD;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready && keep;

   assign job.op      = op;
   assign job.index_a = req_data.index_a;
   assign job.index_b = req_data.index_b;
   assign job.index_c = req_data.index_c;
   assign job.pos_x   = req_data.pos_x;
   assign job.pos_y   = req_data.pos_y;
   assign job.pos_z   = req_data.pos_z;

endmodule

FILE: sv/vna_queue.sv
// ----------------------------------------------------------------------------
// vna_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module vna_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vna_pkg::job_type  push_job,
   input  logic              pop,
   output vna_pkg::job_type  pop_job,
   output logic              full,
   output logic              not_empty
);
   import vna_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full      = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("job queue read while empty");

endmodule

FILE: sv/vna_norm.sv
// ----------------------------------------------------------------------------
// vna_norm
// Scales a cross product to unit length, Q1.15, with a serial root and divider.
// ----------------------------------------------------------------------------
module vna_norm (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [vna_pkg::CROSS_W-1:0]   cross_x,
   input  logic signed [vna_pkg::CROSS_W-1:0]   cross_y,
   input  logic signed [vna_pkg::CROSS_W-1:0]   cross_z,
   output logic                                 done,
   output logic signed [vna_pkg::UNIT_W-1:0]    unit_x,
   output logic signed [vna_pkg::UNIT_W-1:0]    unit_y,
   output logic signed [vna_pkg::UNIT_W-1:0]    unit_z
);
   import vna_pkg::*;

   norm_state_type state_ff, state_in;

   logic [MAG_W-1:0]         mag_ff [3];
   logic                     neg_ff [3];
   logic [SQ_W-1:0]          n_ff, root_ff;
   logic [4:0]               cnt_ff;
   logic [1:0]               comp_ff;
   logic [LEN_W-1:0]         len_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [QUOT_W-1:0]        low_ff, quot_ff;
   logic signed [UNIT_W-1:0] unit_ff [3];

   logic signed [CROSS_W-1:0] cr [3];
   logic [CROSS_W-1:0]        abs_v [3];
   logic [MAG_W-1:0]          mx;
   logic [SCALED_W-1:0]       sel;
   logic [2*SCALED_W-1:0]     sqr;
   logic [SQ_W-1:0]           bit_v, trial;
   logic                      root_take;
   logic [SQ_W-1:0]           root_next;
   logic [NUM_W-1:0]          num;
   logic [LEN_W-1:0]          r2;
   logic                      div_take;
   logic [QUOT_W-1:0]         quot_next;
   logic [UNIT_W-1:0]         q_sat;

   assign cr[0] = cross_x;
   assign cr[1] = cross_y;
   assign cr[2] = cross_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
      end
   end

   assign mx = (mag_ff[0] >= mag_ff[1] && mag_ff[0] >= mag_ff[2]) ? mag_ff[0] :
               (mag_ff[1] >= mag_ff[2]) ? mag_ff[1] : mag_ff[2];

   assign sel = mag_ff[comp_ff][SCALED_W-1:0];
   assign sqr = sel * sel;

   // root: one result bit per cycle, test bit 4^cnt
   assign bit_v     = SQ_W'(1) << {cnt_ff, 1'b0};
   assign trial     = root_ff + bit_v;
   assign root_take = n_ff >= trial;
   assign root_next = root_take ? (root_ff >> 1) + bit_v : root_ff >> 1;

   // rounded quotient: (mag * 2^15 + len / 2) / len, one bit per cycle
   assign num       = (NUM_W'(sel) << 15) + NUM_W'(len_ff >> 1);
   assign r2        = {rem_ff, low_ff[QUOT_W-1]};
   assign div_take  = r2 >= len_ff;
   assign quot_next = {quot_ff[QUOT_W-2:0], div_take};
   assign q_sat     = (quot_next[QUOT_W-1:UNIT_W-1] != '0) ? UNIT_W'(16'h7FFF)
                                                        : quot_next[UNIT_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               state_in = (cr[0] == '0 && cr[1] == '0 && cr[2] == '0) ? N_DONE : N_SCALE;
            end
         end
         N_SCALE: begin
            if (mx[MAG_W-1:SCALED_W] == '0 && mx[SCALED_W-1]) begin
               state_in = N_SQUARE;
            end
         end
         N_SQUARE: begin
            if (comp_ff == 2'd2) begin
               state_in = N_ROOT;
            end
         end
         N_ROOT: begin
            if (cnt_ff == '0) begin
               state_in = N_DIV_LOAD;
            end
         end
         N_DIV_LOAD: state_in = N_DIV_STEP;
         N_DIV_STEP: begin
            if (cnt_ff == '0) begin
               state_in = (comp_ff == 2'd2) ? N_DONE : N_DIV_LOAD;
            end
         end
         N_DONE:  state_in = N_IDLE;
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         N_IDLE: begin
            // unit result holds until the next start
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= abs_v[i][MAG_W-1:0];
               neg_ff[i] <= cr[i][CROSS_W-1];
               if (start) begin
                  unit_ff[i] <= '0;
               end
            end
            n_ff    <= '0;
            comp_ff <= '0;
         end
         N_SCALE: begin
            // truncating one step at a time gives the same as one big shift
            for (int i = 0; i < 3; i++) begin
               if (mx[MAG_W-1:SCALED_W] != '0) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (mx[SCALED_W-1:SCALED_W-4] == '0) begin
                  mag_ff[i] <= mag_ff[i] << 4;
               end else if (!mx[SCALED_W-1]) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         N_SQUARE: begin
            n_ff    <= n_ff + SQ_W'(sqr);
            comp_ff <= comp_ff + 1'b1;
            root_ff <= '0;
            cnt_ff  <= 5'd31;
         end
         N_ROOT: begin
            if (root_take) begin
               n_ff <= n_ff - trial;
            end
            root_ff <= root_next;
            cnt_ff  <= cnt_ff - 1'b1;
            len_ff  <= root_next[LEN_W-1:0];
            comp_ff <= '0;
         end
         N_DIV_LOAD: begin
            rem_ff  <= REM_W'(num[NUM_W-1:QUOT_W]);
            low_ff  <= num[QUOT_W-1:0];
            quot_ff <= '0;
            cnt_ff  <= 5'(QUOT_W - 1);
         end
         N_DIV_STEP: begin
            rem_ff  <= div_take ? REM_W'(r2 - len_ff) : r2[REM_W-1:0];
            low_ff  <= low_ff << 1;
            quot_ff <= quot_next;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               unit_ff[comp_ff] <= neg_ff[comp_ff] ? -signed'(q_sat) : signed'(q_sat);
               comp_ff <= comp_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign done   = state_ff == N_DONE;
   assign unit_x = unit_ff[0];
   assign unit_y = unit_ff[1];
   assign unit_z = unit_ff[2];

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      done |-> (unit_x != -16'sd32768 && unit_y != -16'sd32768 && unit_z != -16'sd32768))
      else $error("unit component outside Q1.15 range");

endmodule

FILE: sv/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back
// Runs queued jobs against the position and normal-sum memories.
// ----------------------------------------------------------------------------
module vna_back #(
   parameter int VERTEX_COUNT    = vna_pkg::VERTEX_COUNT_DEF,
   parameter int NORMAL_SUM_BITS = vna_pkg::NORMAL_SUM_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  vna_pkg::job_type  job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vna_pkg::rsp_type  rsp_data
);
   import vna_pkg::*;

   localparam int ADDR_W = $clog2(VERTEX_COUNT);
   localparam int NSB    = NORMAL_SUM_BITS;
   localparam int SUM_W  = 3 * NSB;
   localparam int PW3    = 3 * POS_W;

   logic [PW3-1:0]   pos_mem [VERTEX_COUNT];
   logic [SUM_W-1:0] sum_mem [VERTEX_COUNT];
   logic [PW3-1:0]   pos_rd_ff;
   logic [SUM_W-1:0] sum_rd_ff;

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [1:0]     corner_ff;
   logic [2:0]     mcnt_ff;
   logic [PW3-1:0] cpos_ff [3];
   logic signed [EDGE_W-1:0]  e1_ff [3];
   logic signed [EDGE_W-1:0]  e2_ff [3];
   logic signed [PROD_W-1:0]  prod_ff, first_ff;
   logic signed [CROSS_W-1:0] cross_ff [3];
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic                     pos_we, pos_re, sum_we, sum_re, norm_start, norm_done, slot_free;
   logic [INDEX_W-1:0]       corner_idx;
   logic [ADDR_W-1:0]        addr;
   logic [SUM_W-1:0]         sum_wdata, acc_word;
   logic signed [UNIT_W-1:0] unit_v [3];
   logic signed [EDGE_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   function automatic logic [NSB-1:0] sat_add(input logic [NSB-1:0] sum,
                                              input logic signed [UNIT_W-1:0] add);
      logic signed [NSB:0] wide;
      wide = signed'({sum[NSB-1], sum}) + (NSB+1)'(add);
      if (wide[NSB] != wide[NSB-1]) begin
         return wide[NSB] ? {1'b1, {(NSB-1){1'b0}}} : {1'b0, {(NSB-1){1'b1}}};
      end
      return wide[NSB-1:0];
   endfunction

   always_comb begin
      unique case (corner_ff)
         2'd0:    corner_idx = job_ff.index_a;
         2'd1:    corner_idx = job_ff.index_b;
         default: corner_idx = job_ff.index_c;
      endcase
   end

   assign addr = (state_ff == B_LOAD || state_ff == B_RD_ISSUE) ? ADDR_W'(job_ff.index_a)
                                                               : ADDR_W'(corner_idx);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc_word[k*NSB +: NSB] = sat_add(sum_rd_ff[k*NSB +: NSB], unit_v[k]);
      end
   end

   assign sum_wdata = (state_ff == B_LOAD) ? '0 : acc_word;

   // cross product: one signed 17x17 product per cycle
   always_comb begin
      unique case (mcnt_ff)
         3'd0: begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1: begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2: begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3: begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4: begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         3'd5: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      job_pop    = 1'b0;
      pos_we     = 1'b0;
      pos_re     = 1'b0;
      sum_we     = 1'b0;
      sum_re     = 1'b0;
      norm_start = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               unique case (job.op)
                  OP_LOAD:     state_in = B_LOAD;
                  OP_TRIANGLE: state_in = B_FETCH;
                  OP_READ:     state_in = B_RD_ISSUE;
                  default:     state_in = B_RSP;
               endcase
            end
         end
         B_LOAD: begin
            pos_we   = 1'b1;
            sum_we   = 1'b1;
            state_in = B_IDLE;
         end
         B_FETCH: begin
            pos_re   = 1'b1;
            state_in = B_CATCH;
         end
         B_CATCH:     state_in = (corner_ff == 2'd2) ? B_EDGE : B_FETCH;
         B_EDGE:      state_in = B_CROSS;
         B_CROSS:     state_in = (mcnt_ff == 3'd6) ? B_NORM_GO : B_CROSS;
         B_NORM_GO: begin
            norm_start = 1'b1;
            state_in   = B_NORM_WAIT;
         end
         B_NORM_WAIT: state_in = norm_done ? B_ACC_RD : B_NORM_WAIT;
         B_ACC_RD: begin
            sum_re   = 1'b1;
            state_in = B_ACC_WR;
         end
         B_ACC_WR: begin
            sum_we   = 1'b1;
            state_in = (corner_ff == 2'd2) ? B_IDLE : B_ACC_RD;
         end
         B_RD_ISSUE: begin
            sum_re   = 1'b1;
            state_in = B_RSP;
         end
         B_RSP:   state_in = slot_free ? B_IDLE : B_RSP;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[addr] <= {job_ff.pos_z, job_ff.pos_y, job_ff.pos_x};
      end
      if (pos_re) begin
         pos_rd_ff <= pos_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[addr] <= sum_wdata;
      end
      if (sum_re) begin
         sum_rd_ff <= sum_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_RSP && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      unique case (state_ff)
         B_IDLE: begin
            corner_ff <= '0;
            mcnt_ff   <= '0;
         end
         B_CATCH: begin
            cpos_ff[corner_ff] <= pos_rd_ff;
            corner_ff <= (corner_ff == 2'd2) ? 2'd0 : corner_ff + 1'b1;
         end
         B_EDGE: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= EDGE_W'(signed'(cpos_ff[1][i*POS_W +: POS_W]))
                         - EDGE_W'(signed'(cpos_ff[0][i*POS_W +: POS_W]));
               e2_ff[i] <= EDGE_W'(signed'(cpos_ff[2][i*POS_W +: POS_W]))
                         - EDGE_W'(signed'(cpos_ff[0][i*POS_W +: POS_W]));
            end
         end
         B_CROSS: begin
            prod_ff <= mul_p;
            mcnt_ff <= mcnt_ff + 1'b1;
            if (mcnt_ff[0]) begin
               first_ff <= prod_ff;
            end else if (mcnt_ff != '0) begin
               cross_ff[mcnt_ff[2:1] - 2'd1] <= CROSS_W'(first_ff) - CROSS_W'(prod_ff);
            end
         end
         B_ACC_WR: begin
            corner_ff <= corner_ff + 1'b1;
         end
         B_RSP: begin
            if (slot_free) begin
               rsp_ff.vertex_index <= job_ff.index_a;
               if (job_ff.op == OP_READ_ZERO) begin
                  rsp_ff.normal_x <= '0;
                  rsp_ff.normal_y <= '0;
                  rsp_ff.normal_z <= '0;
               end else begin
                  rsp_ff.normal_x <= NORMAL_W'(signed'(sum_rd_ff[0*NSB +: NSB]));
                  rsp_ff.normal_y <= NORMAL_W'(signed'(sum_rd_ff[1*NSB +: NSB]));
                  rsp_ff.normal_z <= NORMAL_W'(signed'(sum_rd_ff[2*NSB +: NSB]));
               end
            end
         end
         default: begin
         end
      endcase
   end

   vna_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .cross_x (cross_ff[0]),
      .cross_y (cross_ff[1]),
      .cross_z (cross_ff[2]),
      .done    (norm_done),
      .unit_x  (unit_v[0]),
      .unit_y  (unit_v[1]),
      .unit_z  (unit_v[2])
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_norm_to_acc : assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_NORM_WAIT && norm_done) |=> state_ff == B_ACC_RD)
      else $error("normal update did not follow normalisation");

endmodule

FILE: dv/vertex_normal_accumulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_tb
// Drives loads, triangles and reads into the accumulator with random idling
// on both sides and checks every read response against an in-bench predictor.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb;
   import vna_pkg::*;

   localparam int NVERT     = 1024;
   localparam int SUM_HI    = (1 << 23) - 1;
   localparam int SUM_LO    = -(1 << 23);
   localparam int CYCLE_CAP = 1000000;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   vertex_normal_accumulator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: positions and normal sums, plus which vertices are loaded
   logic signed [15:0] vpos [NVERT][3];
   longint             vsum [NVERT][3];
   bit                 loaded [NVERT];
   int                 loaded_list[$];

   rsp_type normal_reads_pending[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   int      reads_checked = 0;
   int      tris_sent = 0;
   bit      quiet_tail = 1'b0;

   function automatic longint isqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   function automatic longint clamp_sum(longint s);
      if (s > SUM_HI) return SUM_HI;
      if (s < SUM_LO) return SUM_LO;
      return s;
   endfunction

   // Apply one request to the predictor; queue a response for reads
   function automatic void predict_request(req_type r);
      longint e1[3], e2[3], cr[3], un[3];
      longint unsigned mg[3], mx, sq, ln, q;
      int p, i;
      rsp_type o;
      case (r.command)
         CMD_LOAD: begin
            vpos[r.index_a][0] = r.pos_x;
            vpos[r.index_a][1] = r.pos_y;
            vpos[r.index_a][2] = r.pos_z;
            for (i = 0; i < 3; i++) vsum[r.index_a][i] = 0;
            if (!loaded[r.index_a]) loaded_list.push_back(r.index_a);
            loaded[r.index_a] = 1'b1;
         end
         CMD_TRIANGLE: begin
            for (i = 0; i < 3; i++) begin
               e1[i] = longint'(vpos[r.index_b][i]) - longint'(vpos[r.index_a][i]);
               e2[i] = longint'(vpos[r.index_c][i]) - longint'(vpos[r.index_a][i]);
            end
            cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
            cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
            cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
            mx = 0;
            for (i = 0; i < 3; i++) begin
               mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
               if (mg[i] > mx) mx = mg[i];
            end
            if (mx == 0) begin
               for (i = 0; i < 3; i++) un[i] = 0;   // degenerate: adds nothing
            end else begin
               p = 0;
               while (p < 63 && (mx >> (p + 1)) != 0) p++;
               sq = 0;
               for (i = 0; i < 3; i++) begin
                  if (p > 29) mg[i] >>= (p - 29);
                  else mg[i] <<= (29 - p);
                  sq += mg[i] * mg[i];
               end
               ln = isqrt(sq);
               for (i = 0; i < 3; i++) begin
                  q = ((mg[i] << 15) + (ln >> 1)) / ln;
                  if (q > 32767) q = 32767;
                  un[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
               end
            end
            for (i = 0; i < 3; i++) begin
               vsum[r.index_a][i] = clamp_sum(vsum[r.index_a][i] + un[i]);
               vsum[r.index_b][i] = clamp_sum(vsum[r.index_b][i] + un[i]);
               vsum[r.index_c][i] = clamp_sum(vsum[r.index_c][i] + un[i]);
            end
            tris_sent++;
         end
         CMD_READ: begin
            o.vertex_index = r.index_a;
            o.normal_x = vsum[r.index_a][0][23:0];
            o.normal_y = vsum[r.index_a][1][23:0];
            o.normal_z = vsum[r.index_a][2][23:0];
            normal_reads_pending.push_back(o);
         end
         default: ;   // spare command: ignored
      endcase
   endfunction

   function automatic req_type mk(logic [1:0] c, int a, int b, int cc,
                                  int x, int y, int z);
      req_type r;
      r.command = c;
      r.index_a = INDEX_W'(a); r.index_b = INDEX_W'(b); r.index_c = INDEX_W'(cc);
      r.pos_x = POS_W'(x); r.pos_y = POS_W'(y); r.pos_z = POS_W'(z);
      return r;
   endfunction

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(loaded_list.size() - 1)];
   endfunction

   // Hand one request over; random idle burst ahead of it
   task automatic send_request(req_type r);
      if (!quiet_tail && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(r);
   endtask

   task automatic drain_reads();
      req_valid <= 1'b0;
      while (normal_reads_pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);   // a triangle may still be in flight
   endtask

   // Response side: random stall bursts, then compare against the oldest read
   initial begin
      rsp_type want;
      int      stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (normal_reads_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = normal_reads_pending.pop_front();
               reads_checked++;
               if (rsp_data.vertex_index !== want.vertex_index ||
                   rsp_data.normal_x !== want.normal_x ||
                   rsp_data.normal_y !== want.normal_y ||
                   rsp_data.normal_z !== want.normal_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("read mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
         if (stall > 0) stall--;
         else if (!quiet_tail && $urandom_range(5) == 0) stall = $urandom_range(8, 1);
         rsp_ready <= (stall == 0);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Directed table; vertex 0..2 form a unit right triangle in the xy plane
   req_type directed [] = '{
      mk(CMD_LOAD, 0, 0, 0, 0, 0, 0),
      mk(CMD_LOAD, 1, 0, 0, 256, 0, 0),
      mk(CMD_LOAD, 2, 0, 0, 0, 256, 0),
      mk(CMD_LOAD, 1023, 0, 0, -32768, 32767, -32768),
      mk(CMD_LOAD, 1022, 0, 0, 32767, -32768, 32767),
      mk(CMD_LOAD, 1021, 0, 0, -1, -1, -1),
      mk(CMD_READ, 0, 0, 0, 0, 0, 0),
      mk(CMD_TRIANGLE, 0, 1, 2, 0, 0, 0),
      mk(CMD_READ, 0, 0, 0, 0, 0, 0),
      mk(CMD_TRIANGLE, 0, 0, 1, 0, 0, 0),
      mk(CMD_TRIANGLE, 1023, 1022, 1021, 0, 0, 0),
      mk(CMD_TRIANGLE, 1021, 1023, 1022, 0, 0, 0),
      mk(CMD_TRIANGLE, 2, 1, 0, 0, 0, 0),
      mk(CMD_SPARE, 1023, 1023, 1023, -1, -1, -1),
      mk(CMD_READ, 1023, 0, 0, 0, 0, 0),
      mk(CMD_READ, 1022, 0, 0, 0, 0, 0),
      mk(CMD_READ, 1021, 0, 0, 0, 0, 0),
      mk(CMD_READ, 1, 0, 0, 0, 0, 0),
      mk(CMD_LOAD, 1, 0, 0, 0, 0, 256),
      mk(CMD_READ, 1, 0, 0, 0, 0, 0),
      mk(CMD_READ, 2, 0, 0, 0, 0, 0)
   };
   // Rows whose answer is obvious by inspection: fresh load, and +z normal
   int      known_row [] = '{6, 8, 19};
   rsp_type known_rsp [] = '{
      '{vertex_index: 0, normal_x: 0, normal_y: 0, normal_z: 0},
      '{vertex_index: 0, normal_x: 0, normal_y: 0, normal_z: 32767},
      '{vertex_index: 1, normal_x: 0, normal_y: 0, normal_z: 0}
   };

   initial begin
      req_type r;
      int      k, pick, v, hot;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < directed.size(); i++) begin
         send_request(directed[i]);
         for (k = 0; k < known_row.size(); k++)
            if (known_row[k] == i && normal_reads_pending[$] !== known_rsp[k]) begin
               mismatches++;
               $display("row %0d: predictor gives %p, expected %p", i,
                        normal_reads_pending[$], known_rsp[k]);
            end
      end

      // Sender holds off until everything outstanding has come back
      drain_reads();

      // Saturation: the same +z face on three vertices until their sums clamp
      send_request(mk(CMD_LOAD, 10, 0, 0, 0, 0, 0));
      send_request(mk(CMD_LOAD, 11, 0, 0, 256, 0, 0));
      send_request(mk(CMD_LOAD, 12, 0, 0, 0, 256, 0));
      for (int i = 0; i < 260; i++) send_request(mk(CMD_TRIANGLE, 10, 11, 12, 0, 0, 0));
      send_request(mk(CMD_READ, 10, 0, 0, 0, 0, 0));

      for (int n = 0; n < 250; n++) begin
         if (n == 210) quiet_tail = 1'b1;
         pick = $urandom_range(99);
         hot  = $urandom_range(3);
         if (pick < 20 || loaded_list.size() < 3) begin
            v = hot == 0 ? $urandom_range(1023) : $urandom_range(31);
            r = mk(CMD_LOAD, v, $urandom, $urandom, $urandom, $urandom, $urandom);
            if (hot == 1) begin   // small coordinates so normals vary finely
               r.pos_x = POS_W'($urandom_range(64) - 32);
               r.pos_y = POS_W'($urandom_range(64) - 32);
               r.pos_z = POS_W'($urandom_range(64) - 32);
            end
         end else if (pick < 65) begin
            r = mk(CMD_TRIANGLE, pick_loaded(), pick_loaded(), pick_loaded(),
                   $urandom, $urandom, $urandom);
         end else if (pick < 95) begin
            r = mk(CMD_READ, pick_loaded(), $urandom, $urandom,
                   $urandom, $urandom, $urandom);
         end else begin
            r = mk(CMD_SPARE, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
         end
         send_request(r);
      end

      drain_reads();

      $display("%0d reads checked over %0d triangles on %0d loaded vertices",
               reads_checked, tris_sent, loaded_list.size());
      if (mismatches == 0 && normal_reads_pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d reads outstanding",
                  mismatches, normal_reads_pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      for (int i = 0; i < NVERT; i++) loaded[i] = 1'b0;
   end

endmodule

FILE: sim.f
sv/vna_pkg.sv
sv/vna_front.sv
sv/vna_queue.sv
sv/vna_norm.sv
sv/vna_back.sv
sv/vertex_normal_accumulator.sv
dv/vertex_normal_accumulator_tb.sv
